@@ rtl/lkt_pkg.sv @@
package lkt_pkg;

   // Table geometry.
   localparam int CAPACITY = 64;
   localparam int KEY_BITS = 64;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int STAMP_W  = 32;
   localparam logic [STAMP_W-1:0] STAMP_MAX = '1;

   // Result status codes.
   localparam logic [2:0] ST_MOVED    = 3'd0;
   localparam logic [2:0] ST_INSERTED = 3'd1;
   localparam logic [2:0] ST_RELEASED = 3'd2;
   localparam logic [2:0] ST_EMPTY    = 3'd3;
   localparam logic [2:0] ST_REFUSED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;
   localparam logic [2:0] ST_IGNORED  = 3'd6;

   // Request kinds.
   localparam logic KIND_TOUCH   = 1'b0;
   localparam logic KIND_RELEASE = 1'b1;

   // One result word as it leaves the engine.
   typedef struct packed {
      logic [2:0]          status;
      logic [KEY_BITS-1:0] victim_key;
      logic                has_entries;
   } res_type;

endpackage

@@ rtl/lkt_req_if.sv @@
interface lkt_req_if;
   import lkt_pkg::*;

   logic                valid;
   logic                ready;
   logic                kind;
   logic [KEY_BITS-1:0] key;
   logic                store_refused;

   modport source (output valid, kind, key, store_refused, input ready);
   modport sink   (input valid, kind, key, store_refused, output ready);
endinterface

@@ rtl/lkt_rsp_if.sv @@
interface lkt_rsp_if;
   import lkt_pkg::*;

   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic [KEY_BITS-1:0] victim_key;
   logic                has_entries;

   modport source (output valid, status, victim_key, has_entries, input ready);
   modport sink   (input valid, status, victim_key, has_entries, output ready);
endinterface

@@ rtl/lkt_engine.sv @@
module lkt_engine (
   input  logic            clock,
   input  logic            reset,
   input  logic            lru_en,
   lkt_req_if.sink         req_ch,
   output logic            res_valid,
   output lkt_pkg::res_type res,
   input  logic            res_take
);
   import lkt_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE    = 7'b0000001,
      S_SCAN    = 7'b0000010,
      S_RN_CHK  = 7'b0000100,
      S_RN_SCAN = 7'b0001000,
      S_RN_WR   = 7'b0010000,
      S_UPD     = 7'b0100000,
      S_FIN     = 7'b1000000
   } state_type;

   state_type state_ff;

   // Key and stamp memories, one read port and one write port each.
   logic [KEY_BITS-1:0] key_mem   [CAPACITY];
   logic [STAMP_W-1:0]  stamp_mem [CAPACITY];
   logic [KEY_BITS-1:0] key_q;
   logic [STAMP_W-1:0]  stamp_q;

   logic                kind_ff;
   logic [KEY_BITS-1:0] key_ff;
   logic                refused_ff;
   logic [CNT_W-1:0]    issue_ff;
   logic                p_vld_ff;
   logic [IDX_W-1:0]    p_idx_ff;
   logic                found_ff;
   logic [IDX_W-1:0]    best_idx_ff;
   logic [STAMP_W-1:0]  best_stamp_ff;
   logic [KEY_BITS-1:0] best_key_ff;
   logic                free_found_ff;
   logic [IDX_W-1:0]    free_idx_ff;
   logic [CAPACITY-1:0] valid_ff;
   logic [CAPACITY-1:0] done_ff;
   logic [CNT_W-1:0]    count_ff;
   logic [STAMP_W-1:0]  stamp_ff;
   logic [CNT_W-1:0]    rank_ff;
   logic [IDX_W-1:0]    target_ff;
   logic                insert_ff;
   logic [2:0]          status_ff;
   logic [KEY_BITS-1:0] victim_ff;

   logic                scanning;
   logic                scan_done;
   logic                p_v;
   logic                cand;
   logic                stamp_we;
   logic [IDX_W-1:0]    stamp_waddr;
   logic [STAMP_W-1:0]  stamp_wdata;
   logic                key_we;

   // Scan pipeline control.
   assign scanning  = (state_ff == S_SCAN) || (state_ff == S_RN_SCAN);
   assign scan_done = (issue_ff == CNT_W'(CAPACITY)) && !p_vld_ff;
   assign p_v       = valid_ff[p_idx_ff];
   assign cand      = p_v && ((state_ff == S_SCAN) || !done_ff[p_idx_ff]);

   // Memory write selection.
   assign stamp_we    = (state_ff == S_UPD) || (state_ff == S_RN_WR);
   assign stamp_waddr = (state_ff == S_UPD) ? target_ff : best_idx_ff;
   assign stamp_wdata = (state_ff == S_UPD) ? stamp_ff : STAMP_W'(rank_ff);
   assign key_we      = (state_ff == S_UPD) && insert_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[target_ff] <= key_ff;
      end
      if (stamp_we) begin
         stamp_mem[stamp_waddr] <= stamp_wdata;
      end
      key_q   <= key_mem[issue_ff[IDX_W-1:0]];
      stamp_q <= stamp_mem[issue_ff[IDX_W-1:0]];
   end

   // Handshake and result word.
   assign req_ch.ready    = (state_ff == S_IDLE);
   assign res_valid       = (state_ff == S_FIN);
   assign res.status      = status_ff;
   assign res.victim_key  = victim_ff;
   assign res.has_entries = lru_en && (count_ff != '0);

   // Sequencer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         count_ff <= '0;
         stamp_ff <= '0;
         p_vld_ff <= 1'b0;
      end else begin
         // Entry processing for the word read in the previous cycle.
         if (scanning) begin
            if (issue_ff != CNT_W'(CAPACITY)) begin
               issue_ff <= issue_ff + 1'b1;
               p_vld_ff <= 1'b1;
               p_idx_ff <= issue_ff[IDX_W-1:0];
            end else begin
               p_vld_ff <= 1'b0;
            end
            if (p_vld_ff) begin
               if (state_ff == S_SCAN && kind_ff == KIND_TOUCH) begin
                  if (p_v && key_q == key_ff && !found_ff) begin
                     found_ff    <= 1'b1;
                     best_idx_ff <= p_idx_ff;
                  end
                  if (!p_v && !free_found_ff) begin
                     free_found_ff <= 1'b1;
                     free_idx_ff   <= p_idx_ff;
                  end
               end else if (cand && (!found_ff || stamp_q < best_stamp_ff)) begin
                  found_ff      <= 1'b1;
                  best_idx_ff   <= p_idx_ff;
                  best_stamp_ff <= stamp_q;
                  best_key_ff   <= key_q;
               end
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (req_ch.valid) begin
                  kind_ff       <= req_ch.kind;
                  key_ff        <= req_ch.key;
                  refused_ff    <= req_ch.store_refused;
                  issue_ff      <= '0;
                  p_vld_ff      <= 1'b0;
                  found_ff      <= 1'b0;
                  free_found_ff <= 1'b0;
                  victim_ff     <= '0;
                  if (!lru_en) begin
                     status_ff <= (req_ch.kind == KIND_RELEASE) ? ST_REFUSED : ST_IGNORED;
                     state_ff  <= S_FIN;
                  end else begin
                     state_ff <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (scan_done) begin
                  if (kind_ff == KIND_TOUCH) begin
                     if (found_ff || free_found_ff) begin
                        target_ff <= found_ff ? best_idx_ff : free_idx_ff;
                        insert_ff <= !found_ff;
                        if (stamp_ff == STAMP_MAX) begin
                           done_ff  <= '0;
                           rank_ff  <= '0;
                           state_ff <= S_RN_CHK;
                        end else begin
                           state_ff <= S_UPD;
                        end
                     end else begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_FIN;
                     end
                  end else begin
                     if (!found_ff) begin
                        status_ff <= ST_EMPTY;
                     end else begin
                        victim_ff <= best_key_ff;
                        if (refused_ff) begin
                           status_ff <= ST_REFUSED;
                        end else begin
                           valid_ff[best_idx_ff] <= 1'b0;
                           count_ff              <= count_ff - 1'b1;
                           status_ff             <= ST_RELEASED;
                        end
                     end
                     state_ff <= S_FIN;
                  end
               end
            end
            S_RN_CHK: begin
               // Renumber held entries by age, oldest first.
               if (rank_ff == count_ff) begin
                  stamp_ff <= STAMP_W'(count_ff);
                  state_ff <= S_UPD;
               end else begin
                  issue_ff <= '0;
                  p_vld_ff <= 1'b0;
                  found_ff <= 1'b0;
                  state_ff <= S_RN_SCAN;
               end
            end
            S_RN_SCAN: begin
               if (scan_done) begin
                  state_ff <= S_RN_WR;
               end
            end
            S_RN_WR: begin
               done_ff[best_idx_ff] <= 1'b1;
               rank_ff              <= rank_ff + 1'b1;
               state_ff             <= S_RN_CHK;
            end
            S_UPD: begin
               stamp_ff <= stamp_ff + 1'b1;
               if (insert_ff) begin
                  valid_ff[target_ff] <= 1'b1;
                  count_ff            <= count_ff + 1'b1;
                  status_ff           <= ST_INSERTED;
               end else begin
                  status_ff <= ST_MOVED;
               end
               state_ff <= S_FIN;
            end
            S_FIN: begin
               if (res_take) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

@@ rtl/lru_key_tracker_top.sv @@
// Least recently used key tracker.
// req_ch carries one word per operation: kind (touch or release), key and
// store_refused. rsp_ch returns exactly one word per request: status,
// victim_key and has_entries. csr_we/csr_wdata write lru_enabled; write it
// only while no request is in flight.
// A touch or release scans the whole key table through the key and stamp
// memories, one entry a cycle. In no-eviction mode the engine skips the
// scan and goes straight to its result. When the 32-bit recency stamp runs
// out, the table is renumbered by age first: one full scan per held entry.
// One request is worked on at a time. The next request is accepted while
// the previous response still waits in the output register; a stalled
// receiver only holds the engine once its next response is ready.
// Reset empties the table, clears the stamp counter and sets lru_enabled.
module lru_key_tracker_top (
   input  logic  clock,
   input  logic  reset,
   lkt_req_if.sink   req_ch,
   lkt_rsp_if.source rsp_ch,
   input  logic  csr_we,
   input  logic  csr_wdata
);
   import lkt_pkg::*;

   logic    lru_en_ff;
   logic    rsp_valid_ff;
   res_type rsp_ff;
   logic    res_valid;
   res_type res;
   logic    res_take;

   // Policy register.
   always_ff @(posedge clock) begin
      if (reset) begin
         lru_en_ff <= 1'b1;
      end else if (csr_we) begin
         lru_en_ff <= csr_wdata;
      end
   end

   lkt_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .lru_en    (lru_en_ff),
      .req_ch    (req_ch),
      .res_valid (res_valid),
      .res       (res),
      .res_take  (res_take)
   );

   // Output register decouples the engine from the receiver.
   assign res_take = res_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_ff <= res;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.status      = rsp_ff.status;
   assign rsp_ch.victim_key  = rsp_ff.victim_key;
   assign rsp_ch.has_entries = rsp_ff.has_entries;

   // The engine never takes a request while it offers a result.
   a_ready_vs_result: assert property (@(posedge clock) disable iff (reset)
      !(req_ch.ready && res_valid))
      else $error("engine ready while a result is pending");

   // No-eviction mode reports an empty table.
   a_noevict_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !lru_en_ff |-> !rsp_ch.has_entries)
      else $error("entries reported in no-eviction mode");

   // A victim key only comes with a release or a refusal.
   a_victim_status: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.victim_key != '0 |->
      (rsp_ch.status == ST_RELEASED || rsp_ch.status == ST_REFUSED))
      else $error("victim key on a status without one");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
   import lkt_pkg::*;

   typedef struct packed {
      logic                kind;
      logic [KEY_BITS-1:0] key;
      logic                store_refused;
   } op_word_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   lkt_req_if req_ch ();
   lkt_rsp_if rsp_ch ();

   lru_key_tracker_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Shadow copy of the tracker table.
   logic [KEY_BITS-1:0] trk_key   [CAPACITY];
   logic                trk_valid [CAPACITY];
   logic [STAMP_W-1:0]  trk_stamp [CAPACITY];
   logic [STAMP_W-1:0]  trk_clock;
   int                  trk_count;
   logic                trk_enabled;

   op_word_type pending_ops[$];
   res_type     expected_rsp[$];

   logic [KEY_BITS-1:0] key_pool[16];
   int  mismatches;
   int  stall_cycles;
   bit  no_idle;
   bit  req_taken;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Renumber held entries by age once the stamp counter runs out.
   function automatic logic [STAMP_W-1:0] take_stamp();
      logic [STAMP_W-1:0] rank [CAPACITY];
      logic [STAMP_W-1:0] s;
      if (trk_clock == STAMP_MAX) begin
         for (int i = 0; i < CAPACITY; i++) begin
            rank[i] = '0;
            if (trk_valid[i])
               for (int j = 0; j < CAPACITY; j++)
                  if (trk_valid[j] && trk_stamp[j] < trk_stamp[i]) rank[i]++;
         end
         for (int i = 0; i < CAPACITY; i++)
            if (trk_valid[i]) trk_stamp[i] = rank[i];
         trk_clock = STAMP_W'(trk_count);
      end
      s = trk_clock;
      trk_clock = trk_clock + 1;
      return s;
   endfunction

   // Work out the response word for one request and update the shadow table.
   function automatic res_type track_op(op_word_type op);
      res_type r;
      int hit, free_slot, oldest;
      r = '0;
      hit = CAPACITY;
      free_slot = CAPACITY;
      oldest = CAPACITY;
      if (!trk_enabled) begin
         r.status = (op.kind == KIND_RELEASE) ? ST_REFUSED : ST_IGNORED;
      end else if (op.kind == KIND_TOUCH) begin
         for (int i = 0; i < CAPACITY; i++) begin
            if (trk_valid[i]) begin
               if (hit == CAPACITY && trk_key[i] == op.key) hit = i;
            end else if (free_slot == CAPACITY) begin
               free_slot = i;
            end
         end
         if (hit < CAPACITY) begin
            trk_stamp[hit] = take_stamp();
            r.status = ST_MOVED;
         end else if (free_slot < CAPACITY) begin
            trk_stamp[free_slot] = take_stamp();
            trk_key[free_slot] = op.key;
            trk_valid[free_slot] = 1'b1;
            trk_count++;
            r.status = ST_INSERTED;
         end else begin
            r.status = ST_FULL;
         end
      end else begin
         for (int i = 0; i < CAPACITY; i++)
            if (trk_valid[i] && (oldest == CAPACITY || trk_stamp[i] < trk_stamp[oldest]))
               oldest = i;
         if (oldest == CAPACITY) begin
            r.status = ST_EMPTY;
         end else begin
            r.victim_key = trk_key[oldest];
            if (op.store_refused) begin
               r.status = ST_REFUSED;
            end else begin
               trk_valid[oldest] = 1'b0;
               if (trk_count > 0) trk_count--;
               r.status = ST_RELEASED;
            end
         end
      end
      r.has_entries = trk_enabled && trk_count > 0;
      return r;
   endfunction

   // Driver: present queued words, idling at random.
   // A word is replaced only after the edge that accepted it.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid         <= 1'b0;
         req_ch.kind          <= KIND_TOUCH;
         req_ch.key           <= '0;
         req_ch.store_refused <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (pending_ops.size() > 0 && (no_idle || $urandom_range(99) >= 18)) begin
            req_ch.kind          <= pending_ops[0].kind;
            req_ch.key           <= pending_ops[0].key;
            req_ch.store_refused <= pending_ops[0].store_refused;
            req_ch.valid         <= 1'b1;
            pending_ops.pop_front();
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Receiver backpressure.
   always @(negedge clock) begin
      if (reset) rsp_ch.ready <= 1'b0;
      else       rsp_ch.ready <= no_idle || $urandom_range(99) >= 18;
   end

   // Monitor: predict on acceptance, check each response word.
   always @(posedge clock) begin
      res_type got, want, pred;
      if (reset) begin
         req_taken    <= 1'b0;
         stall_cycles <= 0;
         mismatches = 0;
         for (int i = 0; i < CAPACITY; i++) begin
            trk_valid[i] = 1'b0;
            trk_key[i] = '0;
            trk_stamp[i] = '0;
         end
         trk_clock = '0;
         trk_count = 0;
      end else begin
         req_taken <= req_ch.valid && req_ch.ready;
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
         else
            stall_cycles <= stall_cycles + 1;
         if (req_ch.valid && req_ch.ready) begin
            pred = track_op({req_ch.kind, req_ch.key, req_ch.store_refused});
            expected_rsp.insert(expected_rsp.size(), pred);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = {rsp_ch.status, rsp_ch.victim_key, rsp_ch.has_entries};
            if (expected_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected response word %h", got);
            end else begin
               want = expected_rsp.pop_front();
               if (got.status !== want.status || got.victim_key !== want.victim_key ||
                   got.has_entries !== want.has_entries) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected st=%0d key=%h he=%b, got st=%0d key=%h he=%b",
                              want.status, want.victim_key, want.has_entries,
                              got.status, got.victim_key, got.has_entries);
               end
            end
         end
      end
   end

   // Watchdog on cycles without any accepted word.
   always @(posedge clock) begin
      if (!reset && stall_cycles > 20000) begin
         $display("FAIL");
         $finish;
      end
   end

   // Append one request word to the driver's queue.
   function automatic void queue_op(op_word_type op);
      pending_ops.insert(pending_ops.size(), op);
   endfunction

   task automatic drain();
      while (pending_ops.size() > 0 || req_ch.valid || expected_rsp.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_mode(logic en);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= en;
      @(negedge clock);
      csr_we <= 1'b0;
      trk_enabled = en;
   endtask

   function automatic op_word_type touch_of(logic [KEY_BITS-1:0] k);
      return {KIND_TOUCH, k, 1'b0};
   endfunction

   function automatic op_word_type release_of(logic refused);
      return {KIND_RELEASE, {$urandom, $urandom}, refused};
   endfunction

   // Mostly reused keys so hits and releases are frequent.
   function automatic op_word_type random_op(int release_pct);
      op_word_type op;
      if ($urandom_range(99) < release_pct) begin
         op = release_of($urandom_range(3) == 0);
      end else if ($urandom_range(3) != 0) begin
         op = touch_of(key_pool[$urandom_range(15)] ^ $urandom_range(7));
      end else begin
         op = touch_of({$urandom, $urandom});
      end
      return op;
   endfunction

   initial begin
      csr_we = 1'b0;
      csr_wdata = 1'b0;
      no_idle = 1'b0;
      trk_enabled = 1'b1;
      for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};

      reset = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty release, key extremes, move, refused and normal release.
      queue_op(release_of(1'b0));
      queue_op(release_of(1'b1));
      queue_op(touch_of('0));
      queue_op(touch_of('1));
      queue_op(touch_of(64'h5555_AAAA_5555_AAAA));
      queue_op(touch_of('0));
      queue_op(release_of(1'b1));
      queue_op(release_of(1'b0));
      queue_op(release_of(1'b0));
      queue_op(release_of(1'b0));
      queue_op(release_of(1'b0));
      drain();

      // No-eviction mode, then resume with the table kept.
      queue_op(touch_of('1));
      queue_op(touch_of('1));
      drain();
      write_mode(1'b0);
      queue_op(touch_of(64'h1234));
      queue_op(release_of(1'b0));
      queue_op(release_of(1'b1));
      drain();
      write_mode(1'b1);

      // Fill the table past capacity, then empty it.
      for (int i = 0; i < CAPACITY + 3; i++)
         queue_op(touch_of({$urandom, $urandom}));
      queue_op(touch_of('1));
      for (int i = 0; i < 8; i++) queue_op(random_op(0));
      for (int i = 0; i < CAPACITY + 2; i++) queue_op(release_of(1'b0));
      drain();

      // Random phases with idling, one stretch without, and mode changes.
      for (int ph = 0; ph < 6; ph++) begin
         no_idle = (ph == 2);
         if (ph == 3) write_mode(1'b0);
         if (ph == 4) write_mode(1'b1);
         for (int i = 0; i < 140; i++) queue_op(random_op(ph == 5 ? 60 : 30));
         drain();
      end
      no_idle = 1'b0;

      if (mismatches == 0 && expected_rsp.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
